// ----- sv/gpce_pkg.sv -----
// ----------------------------------------------------------------------------
// GPIO pin change events: shared package
// Register map, result kinds, request types, the configuration record, the
// job record passed from front to back and the pin mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gpce_pkg;

    localparam int DEF_PIN_COUNT = 8;
    localparam int PORT_BITS     = 8;
    localparam int JOB_DEPTH     = 2;
    localparam int ADDR_W        = 5;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] REG_DIR_MASK       = 5'd0;
    localparam logic [ADDR_W-1:0] REG_PULLUP_MASK    = 5'd4;
    localparam logic [ADDR_W-1:0] REG_GROUP_INDEX    = 5'd8;
    localparam logic [ADDR_W-1:0] REG_BATCH_MODE     = 5'd12;
    localparam logic [ADDR_W-1:0] REG_SHARED_HISTORY = 5'd16;

    // Result kinds
    localparam logic [1:0] KIND_PIN   = 2'd0;
    localparam logic [1:0] KIND_BATCH = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    // Request types
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    typedef struct packed {
        logic [7:0] dir_mask;
        logic [7:0] pullup_mask;
        logic [2:0] group_index;
        logic       batch_mode;
        logic       shared_history;
    } cfg_t;

    // One classified item waiting to be turned into results.
    typedef struct packed {
        logic [1:0] kind;
        logic       shared;
        logic [7:0] change;
        logic [7:0] rise;
        logic [7:0] fall;
        logic [7:0] inlev;
        logic [7:0] pad;
    } job_t;

    function automatic logic [7:0] pin_mask(input int count);
        logic [7:0] m;
        if (count >= PORT_BITS)
            m = 8'hFF;
        else
            m = 8'((32'd1 << count) - 32'd1);
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gpce_front.sv -----
// ----------------------------------------------------------------------------
// GPIO pin change events: front end
// Accepts items, updates the output latch and last levels, and turns each
// item that gives results into a job record for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gpce_front #(
    parameter int PIN_COUNT = gpce_pkg::DEF_PIN_COUNT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gpce_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           req_type,
    input  wire logic [2:0]     group,
    input  wire logic [7:0]     pin_levels,
    input  wire logic [2:0]     pin_index,
    input  wire logic           bit_value,
    output logic                push,
    output gpce_pkg::job_t      job,
    input  wire logic           full
);

    localparam logic [7:0] PinMask = gpce_pkg::pin_mask(PIN_COUNT);

    logic [7:0] latch_reg, latch_next;
    logic [7:0] levels_reg, levels_next;
    logic       accept;
    logic [7:0] inputs;
    logic [7:0] lev;
    logic [7:0] change;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign inputs   = ~cfg.dir_mask & PinMask;
    assign lev      = pin_levels & PinMask;
    assign change   = (lev ^ levels_reg) & PinMask;

    always_comb
    begin
        latch_next  = latch_reg;
        levels_next = levels_reg;
        push        = 1'b0;
        job         = '0;
        if (req_type == gpce_pkg::REQ_WRITE)
        begin
            if (int'(pin_index) < PIN_COUNT)
            begin
                if (bit_value)
                    latch_next = latch_reg | (8'd1 << pin_index);
                else
                    latch_next = latch_reg & ~(8'd1 << pin_index);
            end
            job.kind  = gpce_pkg::KIND_ACK;
            job.inlev = levels_reg & inputs;
            job.pad   = ((latch_next & cfg.dir_mask) | (cfg.pullup_mask & ~cfg.dir_mask))
                        & PinMask;
            push      = accept;
        end
        else if (group == cfg.group_index)
        begin
            levels_next = lev;
            job.kind    = cfg.batch_mode ? gpce_pkg::KIND_BATCH : gpce_pkg::KIND_PIN;
            job.shared  = cfg.shared_history;
            job.change  = change;
            job.rise    = lev & ~levels_reg & inputs;
            job.fall    = ~lev & levels_reg & inputs;
            job.inlev   = lev & inputs;
            job.pad     = ((latch_reg & cfg.dir_mask) | (cfg.pullup_mask & ~cfg.dir_mask))
                          & PinMask;
            // Per-pin mode with nothing changed gives no result at all.
            push        = accept && (cfg.batch_mode || (change != 8'd0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= '0;
            levels_reg <= '0;
        end
        else if (accept)
        begin
            latch_reg  <= latch_next;
            levels_reg <= levels_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gpce_fifo.sv -----
// ----------------------------------------------------------------------------
// GPIO pin change events: job queue
// A short first-in first-out queue of job records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gpce_fifo #(
    parameter int DEPTH = gpce_pkg::JOB_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gpce_pkg::job_t wr_job,
    input  wire logic           pop,
    output gpce_pkg::job_t      rd_job,
    output logic                empty,
    output logic                full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    gpce_pkg::job_t mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] n;
        if (p == PtrW'(DEPTH - 1))
            n = '0;
        else
            n = p + PtrW'(1);
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CntW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CntW'(1);
        end
    end

endmodule

`default_nettype wire

// ----- sv/gpce_back.sv -----
// ----------------------------------------------------------------------------
// GPIO pin change events: back end
// Takes one job at a time and issues its results into the output register,
// one per-pin event per cycle while the output is not stalled, lowest changed pin first.
// ----------------------------------------------------------------------------
`default_nettype none

module gpce_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gpce_pkg::job_t rd_job,
    input  wire logic           empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          kind,
    output logic [2:0]          event_pin,
    output logic [7:0]          change_mask,
    output logic [7:0]          rising_mask,
    output logic [7:0]          falling_mask,
    output logic [7:0]          input_levels,
    output logic [7:0]          pad_drive,
    output logic                last
);

    gpce_pkg::job_t cur_reg;
    logic           cur_valid_reg;
    logic [7:0]     rem_reg;

    logic           out_valid_reg;
    logic [1:0]     kind_reg;
    logic [2:0]     pin_reg;
    logic [7:0]     change_reg, rise_reg, fall_reg, inlev_reg, pad_reg;
    logic           last_reg;

    logic           slot_free;
    logic           issue;
    logic [2:0]     low_pin;
    logic [7:0]     low_bit;
    logic [7:0]     rem_next;
    logic [7:0]     hist;
    logic           is_pin;
    logic           fin;

    assign slot_free = !out_valid_reg || out_ready;
    assign issue     = cur_valid_reg && slot_free;
    assign pop       = !cur_valid_reg && !empty;
    assign is_pin    = (cur_reg.kind == gpce_pkg::KIND_PIN);

    always_comb
    begin
        low_pin = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (rem_reg[i])
                low_pin = 3'(i);
        end
    end

    assign low_bit  = 8'd1 << low_pin;
    assign rem_next = rem_reg & ~low_bit;
    assign hist     = cur_reg.shared ? cur_reg.change : low_bit;
    assign fin      = !is_pin || (rem_next == 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (issue && fin)
                cur_valid_reg <= 1'b0;
            if (issue)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= rd_job;
            rem_reg <= rd_job.change;
        end
        else if (issue)
            rem_reg <= rem_next;
        if (issue)
        begin
            kind_reg   <= cur_reg.kind;
            pin_reg    <= is_pin ? low_pin : 3'd0;
            change_reg <= cur_reg.change;
            rise_reg   <= is_pin ? (cur_reg.rise & hist) : cur_reg.rise;
            fall_reg   <= is_pin ? (cur_reg.fall & hist) : cur_reg.fall;
            inlev_reg  <= cur_reg.inlev;
            pad_reg    <= cur_reg.pad;
            last_reg   <= fin;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign event_pin    = pin_reg;
    assign change_mask  = change_reg;
    assign rising_mask  = rise_reg;
    assign falling_mask = fall_reg;
    assign input_levels = inlev_reg;
    assign pad_drive    = pad_reg;
    assign last         = last_reg;

    // A per-pin event always names a pin that is in its change mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == gpce_pkg::KIND_PIN) |-> change_mask[pin_reg])
        else $error("per-pin event names an unchanged pin");

    // Acknowledges and batch events are single results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == gpce_pkg::KIND_ACK || kind_reg == gpce_pkg::KIND_BATCH))
        |-> last_reg)
        else $error("single result without last");

    // An acknowledge carries no change information.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == gpce_pkg::KIND_ACK)
        |-> (change_reg == 8'd0 && rise_reg == 8'd0 && fall_reg == 8'd0))
        else $error("acknowledge carries change masks");

    // Rising and falling pins are always a subset of the changed pins.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((rise_reg | fall_reg) & ~change_reg) == 8'd0))
        else $error("edge mask outside change mask");

endmodule

`default_nettype wire

// ----- sv/gpio_port_pin_change_events_core.sv -----
// ----------------------------------------------------------------------------
// GPIO port with pin change events: top level
// Eight-pin port with output latch, pull-ups and pin change event reporting.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: req_type; tdata: group, pin_levels, pin_index,
//                       bit_value
//  m_axis    out        tuser: kind; tdata: event_pin, change_mask,
//                       rising_mask, falling_mask, input_levels, pad_drive;
//                       tlast: last
//  apb       in/out     dir_mask, pullup_mask, group_index, batch_mode,
//                       shared_history at byte addresses 0, 4, 8, 12, 16
//
// The front end classifies an item in the cycle it is accepted and queues a
// job; the back end then loads the job and issues its results, one per cycle
// while the output register can take them. A sample that gives no result
// queues no job, and no new job is loaded until the last result of the
// current one is issued. The back end's load step plus its issue loop sets
// the sustained rate. A two-entry job queue and the output register let the
// input keep accepting while results wait on m_axis_tready.
// Reset is asynchronous and active low; it clears the latch, the last
// levels, the configuration and all valid flags. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_pin_change_events_core #(
    parameter int PIN_COUNT = gpce_pkg::DEF_PIN_COUNT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input item stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [15:0]                 s_axis_tdata,  // group[2:0], pin_levels[10:3],
                                                            // pin_index[13:11],
                                                            // bit_value[14], zero[15]
    input  wire logic                        s_axis_tuser,  // req_type[0]
    // Result item stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // event_pin[2:0],
                                                            // change_mask[10:3],
                                                            // rising_mask[18:11],
                                                            // falling_mask[26:19],
                                                            // input_levels[34:27],
                                                            // pad_drive[42:35], zero[47:43]
    output logic [1:0]                       m_axis_tuser,  // kind[1:0]
    output logic                             m_axis_tlast,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gpce_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    gpce_pkg::cfg_t cfg_reg;
    gpce_pkg::job_t push_job, pop_job;
    logic           push, pop, q_empty, q_full;
    logic           cfg_write;

    logic [2:0]     event_pin;
    logic [7:0]     change_mask, rising_mask, falling_mask, input_levels, pad_drive;

    // Configuration registers: written on the access cycle of an APB write.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            case (paddr)
                gpce_pkg::REG_DIR_MASK:       cfg_reg.dir_mask       <= pwdata[7:0];
                gpce_pkg::REG_PULLUP_MASK:    cfg_reg.pullup_mask    <= pwdata[7:0];
                gpce_pkg::REG_GROUP_INDEX:    cfg_reg.group_index    <= pwdata[2:0];
                gpce_pkg::REG_BATCH_MODE:     cfg_reg.batch_mode     <= pwdata[0];
                gpce_pkg::REG_SHARED_HISTORY: cfg_reg.shared_history <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back of the register selected by paddr.
    always_comb
    begin
        case (paddr)
            gpce_pkg::REG_DIR_MASK:       prdata = {24'd0, cfg_reg.dir_mask};
            gpce_pkg::REG_PULLUP_MASK:    prdata = {24'd0, cfg_reg.pullup_mask};
            gpce_pkg::REG_GROUP_INDEX:    prdata = {29'd0, cfg_reg.group_index};
            gpce_pkg::REG_BATCH_MODE:     prdata = {31'd0, cfg_reg.batch_mode};
            gpce_pkg::REG_SHARED_HISTORY: prdata = {31'd0, cfg_reg.shared_history};
            default:                      prdata = 32'd0;
        endcase
    end

    // Front end: accepts and classifies items, owns the latch and last levels.
    gpce_front #(
        .PIN_COUNT (PIN_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_type   (s_axis_tuser),
        .group      (s_axis_tdata[2:0]),
        .pin_levels (s_axis_tdata[10:3]),
        .pin_index  (s_axis_tdata[13:11]),
        .bit_value  (s_axis_tdata[14]),
        .push       (push),
        .job        (push_job),
        .full       (q_full)
    );

    // Job queue between the two halves.
    gpce_fifo #(
        .DEPTH (gpce_pkg::JOB_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .pop    (pop),
        .rd_job (pop_job),
        .empty  (q_empty),
        .full   (q_full)
    );

    // Back end: expands each job into its results.
    gpce_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_job       (pop_job),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .kind         (m_axis_tuser),
        .event_pin    (event_pin),
        .change_mask  (change_mask),
        .rising_mask  (rising_mask),
        .falling_mask (falling_mask),
        .input_levels (input_levels),
        .pad_drive    (pad_drive),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, pad_drive, input_levels, falling_mask, rising_mask,
                           change_mask, event_pin};

endmodule

`default_nettype wire

// ----- dv/gpio_port_pin_change_events_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO port with pin change events: self-checking testbench
// Drives write and sample items into the port, programs the configuration
// registers between phases over the APB-style port, and checks every result
// item against a predictor that keeps its own copy of the latch, the last
// pin levels and the configuration. A short directed table comes first,
// then several phases of random items under different settings.
// ----------------------------------------------------------------------------

module gpio_port_pin_change_events_core_tb;

    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int SETTLE_TICKS = 16;    // margin for the back end to finish its last job
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 31;

    // One result item, most significant field first.
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] pin;
        logic [7:0] change;
        logic [7:0] rise;
        logic [7:0] fall;
        logic [7:0] inlev;
        logic [7:0] pad;
        logic       last;
    } port_event_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // A row of the directed table: either an item or a register write.
    typedef struct packed {
        row_kind_t                   kind;
        logic                        req;
        logic [2:0]                  grp;
        logic [7:0]                  lev;
        logic [2:0]                  idx;
        logic                        bitv;
        logic                        typed;
        port_event_t                 ev;
        logic [gpce_pkg::ADDR_W-1:0] addr;
        logic [31:0]                 data;
    } row_t;

    // Result typed into the table for an item, if any, in acceptance order.
    typedef struct packed {
        logic        typed;
        port_event_t ev;
    } override_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [15:0]                 s_axis_tdata  = '0;
    logic                        s_axis_tuser  = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [47:0]                 m_axis_tdata;
    logic [1:0]                  m_axis_tuser;
    logic                        m_axis_tlast;
    logic                        psel          = 1'b0;
    logic                        penable       = 1'b0;
    logic                        pwrite        = 1'b0;
    logic [gpce_pkg::ADDR_W-1:0] paddr         = '0;
    logic [31:0]                 pwdata        = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Predictor state, reset values as the block comes out of reset.
    logic [7:0] shadow_dir    = 8'h00;
    logic [7:0] shadow_pull   = 8'h00;
    logic [2:0] shadow_group  = 3'd0;
    logic       shadow_batch  = 1'b0;
    logic       shadow_shared = 1'b0;
    logic [7:0] shadow_latch  = 8'h00;
    logic [7:0] shadow_levels = 8'h00;

    port_event_t expected_events[$];
    override_t   typed_events[$];
    row_t        plan[$];

    int   fail_count   = 0;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    logic no_idle      = 1'b0;
    logic [7:0] stim_levels = 8'h00;

    gpio_port_pin_change_events_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Pad drive: the latch on output pins, the pull-ups on input pins.
    function automatic logic [7:0] pad_now();
        return (shadow_latch & shadow_dir) | (shadow_pull & ~shadow_dir);
    endfunction

    // Works out the results of one accepted item and advances the state.
    task automatic predict_port(input logic req, input logic [2:0] grp,
                                input logic [7:0] lev, input logic [2:0] idx,
                                input logic bitv);
        logic [7:0]  in_pins;
        logic [7:0]  change;
        logic [7:0]  rise_all;
        logic [7:0]  fall_all;
        logic [7:0]  hist;
        int          top;
        port_event_t ev;
        in_pins = ~shadow_dir;
        if (req == gpce_pkg::REQ_WRITE)
        begin
            shadow_latch[idx] = bitv;
            ev = '0;
            ev.kind  = gpce_pkg::KIND_ACK;
            ev.inlev = shadow_levels & in_pins;
            ev.pad   = pad_now();
            ev.last  = 1'b1;
            expected_events.push_back(ev);
        end
        else if (grp == shadow_group)
        begin
            change   = lev ^ shadow_levels;
            rise_all = lev & ~shadow_levels & in_pins;
            fall_all = ~lev & shadow_levels & in_pins;
            ev = '0;
            ev.change = change;
            ev.inlev  = lev & in_pins;
            ev.pad    = pad_now();
            if (shadow_batch)
            begin
                // A batch event is sent even when nothing has changed.
                ev.kind = gpce_pkg::KIND_BATCH;
                ev.rise = rise_all & change;
                ev.fall = fall_all & change;
                ev.last = 1'b1;
                expected_events.push_back(ev);
            end
            else
            begin
                top = -1;
                for (int i = 0; i < 8; i++)
                    if (change[i])
                        top = i;
                for (int i = 0; i < 8; i++)
                begin
                    if (change[i])
                    begin
                        hist    = shadow_shared ? change : (8'd1 << i);
                        ev.kind = gpce_pkg::KIND_PIN;
                        ev.pin  = 3'(i);
                        ev.rise = rise_all & hist;
                        ev.fall = fall_all & hist;
                        ev.last = (i == top);
                        expected_events.push_back(ev);
                    end
                end
            end
            shadow_levels = lev;
        end
    endtask

    // Watches both streams at the rising edge: predicts on every accepted
    // item, then checks every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        port_event_t got;
        port_event_t want;
        override_t   ov;
        int          before_n;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (s_axis_tvalid && s_axis_tready)
            begin
                ov = typed_events.pop_front();
                before_n = expected_events.size();
                predict_port(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[10:3],
                             s_axis_tdata[13:11], s_axis_tdata[14]);
                if (ov.typed)
                begin
                    // The table gives this row's result outright.
                    while (expected_events.size() > before_n)
                        void'(expected_events.pop_back());
                    expected_events.push_back(ov.ev);
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind   = m_axis_tuser;
                got.pin    = m_axis_tdata[2:0];
                got.change = m_axis_tdata[10:3];
                got.rise   = m_axis_tdata[18:11];
                got.fall   = m_axis_tdata[26:19];
                got.inlev  = m_axis_tdata[34:27];
                got.pad    = m_axis_tdata[42:35];
                got.last   = m_axis_tlast;
                if (expected_events.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected: kind %0d pin %0d",
                                 $realtime, got.kind, got.pin);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got.kind !== want.kind || got.pin !== want.pin ||
                        got.change !== want.change || got.rise !== want.rise ||
                        got.fall !== want.fall || got.inlev !== want.inlev ||
                        got.pad !== want.pad || got.last !== want.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch, fields kind pin change rise fall inlev pad last",
                                     $realtime);
                            $display("    expected %0d %0d %h %h %h %h %h %0d", want.kind,
                                     want.pin, want.change, want.rise, want.fall,
                                     want.inlev, want.pad, want.last);
                            $display("    actual   %0d %0d %h %h %h %h %h %0d", got.kind,
                                     got.pin, got.change, got.rise, got.fall,
                                     got.inlev, got.pad, got.last);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side back-pressure in random bursts, none while no_idle is set.
    always @(negedge clk)
    begin
        if (no_idle)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(4) == 0)
        begin
            stall_left = $urandom_range(8, 1) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("gpio_port_pin_change_events_core verification failed");
        $finish;
    end

    task automatic add_item(input logic req, input logic [2:0] grp, input logic [7:0] lev,
                            input logic [2:0] idx, input logic bitv);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.req  = req;
        r.grp  = grp;
        r.lev  = lev;
        r.idx  = idx;
        r.bitv = bitv;
        plan.push_back(r);
    endtask

    task automatic add_typed(input logic [2:0] idx, input logic bitv, input port_event_t ev);
        row_t r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.req   = gpce_pkg::REQ_WRITE;
        r.idx   = idx;
        r.bitv  = bitv;
        r.typed = 1'b1;
        r.ev    = ev;
        plan.push_back(r);
    endtask

    task automatic add_cfg(input logic [gpce_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.addr = addr;
        r.data = data;
        plan.push_back(r);
    endtask

    // Presents one item from the falling edge and holds it until accepted.
    // tvalid is left high so that the next item can follow straight on.
    task automatic send_item(input row_t r);
        override_t ov;
        int        gap;
        ov.typed = r.typed;
        ov.ev    = r.ev;
        typed_events.push_back(ov);
        @(negedge clk);
        if (!no_idle && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(8, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= {1'b0, r.bitv, r.idx, r.lev, r.grp};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Lowers tvalid, waits for every expected result, then lets the back
    // end finish anything that gives no result.
    task automatic drain_port();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle.
    task automatic reg_write(input logic [gpce_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (addr)
            gpce_pkg::REG_DIR_MASK:       shadow_dir    = data[7:0];
            gpce_pkg::REG_PULLUP_MASK:    shadow_pull   = data[7:0];
            gpce_pkg::REG_GROUP_INDEX:    shadow_group  = data[2:0];
            gpce_pkg::REG_BATCH_MODE:     shadow_batch  = data[0];
            gpce_pkg::REG_SHARED_HISTORY: shadow_shared = data[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        port_event_t ack_idle;
        row_t        r;
        int          counted;
        int          pick;
        logic [7:0]  cfg_dir;
        logic [7:0]  cfg_pull;
        logic [2:0]  cfg_grp;
        logic        cfg_batch;
        logic        cfg_shared;

        // Acknowledge straight after reset: all inputs, no pull-ups and no
        // sample seen yet, so every field but the kind and last is zero.
        ack_idle = {gpce_pkg::KIND_ACK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};

        // Reset configuration: per-pin mode, private history, group 0.
        add_typed(3'd0, 1'b1, ack_idle);
        add_item(gpce_pkg::REQ_SAMPLE, 3'd0, 8'h00, 3'd0, 1'b0);   // no change, no result
        add_item(gpce_pkg::REQ_SAMPLE, 3'd0, 8'hFF, 3'd0, 1'b0);   // every pin rises
        add_item(gpce_pkg::REQ_SAMPLE, 3'd5, 8'h00, 3'd0, 1'b0);   // other group, ignored
        add_item(gpce_pkg::REQ_SAMPLE, 3'd0, 8'h00, 3'd7, 1'b1);   // every pin falls
        add_item(gpce_pkg::REQ_WRITE,  3'd7, 8'hFF, 3'd7, 1'b1);
        // All pins outputs: no rising or falling, pad shows the latch.
        add_cfg(gpce_pkg::REG_DIR_MASK, 32'h0000_00FF);
        add_item(gpce_pkg::REQ_WRITE,  3'd0, 8'h00, 3'd7, 1'b0);
        add_item(gpce_pkg::REQ_SAMPLE, 3'd0, 8'h81, 3'd0, 1'b0);
        // Mixed directions with pull-ups, batch events on group 7.
        add_cfg(gpce_pkg::REG_DIR_MASK, 32'h0000_000F);
        add_cfg(gpce_pkg::REG_PULLUP_MASK, 32'h0000_00F0);
        add_cfg(gpce_pkg::REG_GROUP_INDEX, 32'h0000_0007);
        add_cfg(gpce_pkg::REG_BATCH_MODE, 32'h0000_0001);
        add_item(gpce_pkg::REQ_SAMPLE, 3'd7, 8'h81, 3'd0, 1'b0);   // batch, nothing changed
        add_item(gpce_pkg::REQ_SAMPLE, 3'd7, 8'h7E, 3'd0, 1'b0);
        add_item(gpce_pkg::REQ_SAMPLE, 3'd0, 8'h00, 3'd0, 1'b0);   // other group, ignored
        add_item(gpce_pkg::REQ_WRITE,  3'd0, 8'h00, 3'd3, 1'b1);
        // Per-pin events sharing the history of every changed pin.
        add_cfg(gpce_pkg::REG_BATCH_MODE, 32'h0000_0000);
        add_cfg(gpce_pkg::REG_SHARED_HISTORY, 32'h0000_0001);
        add_item(gpce_pkg::REQ_SAMPLE, 3'd7, 8'h5A, 3'd0, 1'b0);
        add_item(gpce_pkg::REQ_SAMPLE, 3'd7, 8'hA5, 3'd0, 1'b0);
        add_item(gpce_pkg::REQ_WRITE,  3'd0, 8'h00, 3'd0, 1'b0);

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
            begin
                drain_port();
                reg_write(plan[k].addr, plan[k].data);
            end
            else
                send_item(plan[k]);
        end

        // Random phases; the first two take the register extremes.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    cfg_dir = 8'h00; cfg_pull = 8'hFF; cfg_grp = 3'd7;
                    cfg_batch = 1'b0; cfg_shared = 1'b0;
                end
                1:
                begin
                    cfg_dir = 8'hFF; cfg_pull = 8'h00; cfg_grp = 3'd0;
                    cfg_batch = 1'b1; cfg_shared = 1'b1;
                end
                default:
                begin
                    cfg_dir    = 8'($urandom);
                    cfg_pull   = 8'($urandom);
                    cfg_grp    = 3'($urandom);
                    cfg_batch  = 1'($urandom);
                    cfg_shared = 1'($urandom);
                end
            endcase
            drain_port();
            reg_write(gpce_pkg::REG_DIR_MASK, {24'd0, cfg_dir});
            reg_write(gpce_pkg::REG_PULLUP_MASK, {24'd0, cfg_pull});
            reg_write(gpce_pkg::REG_GROUP_INDEX, {29'd0, cfg_grp});
            reg_write(gpce_pkg::REG_BATCH_MODE, {31'd0, cfg_batch});
            reg_write(gpce_pkg::REG_SHARED_HISTORY, {31'd0, cfg_shared});
            stim_levels = shadow_levels;
            // The final phase runs with both sides flat out.
            no_idle = (phase == PHASES - 1);

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                // Midway through each phase the sender holds off until all is delivered.
                if (counted == PHASE_ITEMS / 2)
                    drain_port();
                r = '0;
                r.kind = ROW_ITEM;
                pick = $urandom_range(99);
                if (pick < 25)
                begin
                    r.req  = gpce_pkg::REQ_WRITE;
                    r.grp  = 3'($urandom);
                    r.lev  = 8'($urandom);
                    r.idx  = 3'($urandom);
                    r.bitv = 1'($urandom);
                    counted++;
                end
                else if (pick < 37)
                begin
                    // Sample for another group: the block ignores it.
                    r.req = gpce_pkg::REQ_SAMPLE;
                    r.grp = shadow_group ^ 3'($urandom_range(7, 1));
                    r.lev = 8'($urandom);
                end
                else
                begin
                    r.req = gpce_pkg::REQ_SAMPLE;
                    r.grp = shadow_group;
                    case ($urandom_range(9))
                        0:       r.lev = stim_levels;
                        1:       r.lev = ~stim_levels;
                        2, 3, 4: r.lev = stim_levels ^ (8'd1 << $urandom_range(7));
                        5:       r.lev = stim_levels ^ 8'($urandom) ^ 8'($urandom);
                        default: r.lev = 8'($urandom);
                    endcase
                    r.idx  = 3'($urandom);
                    r.bitv = 1'($urandom);
                    stim_levels = r.lev;
                    counted++;
                end
                send_item(r);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS + 4)
            @(posedge clk);

        if (fail_count == 0 && expected_events.size() == 0)
            $display("gpio_port_pin_change_events_core verification clean");
        else
            $display("gpio_port_pin_change_events_core verification failed");
        $finish;
    end

endmodule

// ----- gpio_port_pin_change_events_core.f -----
sv/gpce_pkg.sv
sv/gpce_front.sv
sv/gpce_fifo.sv
sv/gpce_back.sv
sv/gpio_port_pin_change_events_core.sv
dv/gpio_port_pin_change_events_core_tb.sv
